/* rtl/ial_pkg.sv */
package ial_pkg;

    // Fixed field widths of the streaming payload.
    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;
    localparam int DATA_W   = 32;
    localparam int FOUND_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_GET    = 3'd2;
    localparam logic [OP_W-1:0] OP_SET    = 3'd3;
    localparam logic [OP_W-1:0] OP_INDEX  = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_MISSING = 2'd3;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WALK = 4'b0010,
        ST_FIN  = 4'b0100,
        ST_DONE = 4'b1000
    } ial_state_t;

endpackage

/* rtl/ial_ram.sv */
module ial_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with a registered output.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/indexed_array_list_top.sv */
// Ordered list of up to CAPACITY values kept in one simple dual-port memory
// (one write and one registered read per cycle). Insert moves the entries at
// or above the given position up, and remove moves the entries above it down,
// one slot per cycle. Steps of each operation:
// - An insert walks from the top entry down to the position, then writes the
//   new value in its place; an append at the end writes it at once.
// - A remove reads from the position to the top, keeps the removed entry and
//   writes each entry above it one slot lower.
// - Index-of scans from position zero and stops at the first match or after
//   the last entry; on an empty list it reads nothing.
// - Get reads the entry; set reads the old entry and writes the new value.
// - Clear, unused codes and rejected requests go straight to the result.
// The next item is accepted in the cycle after the load. The load waits for as
// long as the previous result is still held in the output register by a
// stalled receiver. Only one item is in work at a time, and memory entries at
// or above the count are never read.
module indexed_array_list_top #(
    parameter int CAPACITY   = 64,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: operation[2:0], position[9:3], value[41:10], zero fill
    input  logic [ial_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // m_tdata: status[1:0], data[33:2], found_at[39:34], count[46:40], zero fill
    output logic [ial_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready
);

    import ial_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Input field unpacking.
    logic [OP_W-1:0]  in_op;
    logic [POS_W-1:0] in_pos;
    logic [VAL_W-1:0] in_val;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;

    assign in_op   = s_tdata[OP_W-1:0];
    assign in_pos  = s_tdata[OP_W+POS_W-1:OP_W];
    assign in_val  = s_tdata[OP_W+POS_W+VAL_W-1:OP_W+POS_W];

    // Control and work registers.
    ial_state_t            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [OP_W-1:0]       op_reg, op_next;
    logic [IDX_W-1:0]      pos_reg, pos_next;
    logic [ELEM_WIDTH-1:0] val_reg, val_next;
    logic [STAT_W-1:0]     status_reg, status_next;
    logic [ELEM_WIDTH-1:0] data_reg, data_next;
    logic [IDX_W-1:0]      found_reg, found_next;

    // Walk over the memory.
    logic                  issuing_reg, issuing_next;
    logic                  down_reg, down_next;
    logic [IDX_W-1:0]      rd_addr_reg, rd_addr_next;
    logic [IDX_W-1:0]      rd_end_reg, rd_end_next;
    logic                  rvalid_reg;
    logic                  rlast_reg;
    logic [IDX_W-1:0]      raddr_q_reg;
    logic                  rd_en;

    // Output register.
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    // Memory ports.
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [ELEM_WIDTH-1:0] mem_wdata;
    logic [ELEM_WIDTH-1:0] mem_rdata;

    logic                  in_xfer;

    assign pos_ext  = CMP_W'(in_pos);
    assign cnt_ext  = CMP_W'(count_reg);
    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign rd_en    = (state_reg == ST_WALK) && issuing_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    ial_ram #(
        .DEPTH  (CAPACITY),
        .WIDTH  (ELEM_WIDTH),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (rd_en),
        .raddr (rd_addr_reg),
        .rdata (mem_rdata)
    );

    // Sequencer: decode on transfer, walk the memory, finish, hand off result.
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        op_next       = op_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        status_next   = status_reg;
        data_next     = data_reg;
        found_next    = found_reg;
        issuing_next  = issuing_reg;
        down_next     = down_reg;
        rd_addr_next  = rd_addr_reg;
        rd_end_next   = rd_end_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        mem_waddr     = pos_reg;
        mem_wdata     = val_reg;

        // The result waiting at the output leaves on its transfer.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // Advance the read address while the walk is issuing.
        if (rd_en) begin
            if (rd_addr_reg == rd_end_reg) begin
                issuing_next = 1'b0;
            end else if (down_reg) begin
                rd_addr_next = rd_addr_reg - 1'b1;
            end else begin
                rd_addr_next = rd_addr_reg + 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    op_next     = in_op;
                    pos_next    = IDX_W'(in_pos);
                    val_next    = ELEM_WIDTH'(in_val);
                    status_next = STAT_OK;
                    data_next   = '0;
                    found_next  = '0;
                    state_next  = ST_DONE;
                    case (in_op)
                        OP_INSERT: begin
                            if (pos_ext > cnt_ext) begin
                                status_next = STAT_RANGE;
                            end else if (count_reg == CNT_W'(CAPACITY)) begin
                                status_next = STAT_FULL;
                            end else begin
                                count_next = count_reg + 1'b1;
                                if (pos_ext == cnt_ext) begin
                                    state_next = ST_FIN;
                                end else begin
                                    // Move entries up, starting at the top.
                                    rd_addr_next = IDX_W'(count_reg - 1'b1);
                                    rd_end_next  = IDX_W'(in_pos);
                                    down_next    = 1'b1;
                                    issuing_next = 1'b1;
                                    state_next   = ST_WALK;
                                end
                            end
                        end
                        OP_REMOVE, OP_GET, OP_SET: begin
                            if (pos_ext >= cnt_ext) begin
                                status_next = STAT_RANGE;
                            end else begin
                                rd_addr_next = IDX_W'(in_pos);
                                rd_end_next  = (in_op == OP_REMOVE) ?
                                               IDX_W'(count_reg - 1'b1) : IDX_W'(in_pos);
                                down_next    = 1'b0;
                                issuing_next = 1'b1;
                                state_next   = ST_WALK;
                                if (in_op == OP_REMOVE) begin
                                    count_next = count_reg - 1'b1;
                                end
                            end
                        end
                        OP_INDEX: begin
                            status_next = STAT_MISSING;
                            if (count_reg != '0) begin
                                rd_addr_next = '0;
                                rd_end_next  = IDX_W'(count_reg - 1'b1);
                                down_next    = 1'b0;
                                issuing_next = 1'b1;
                                state_next   = ST_WALK;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                // Each read entry is used in the cycle after its address was issued.
                if (rvalid_reg) begin
                    case (op_reg)
                        OP_INSERT: begin
                            mem_we    = 1'b1;
                            mem_waddr = raddr_q_reg + 1'b1;
                            mem_wdata = mem_rdata;
                            if (rlast_reg) begin
                                state_next = ST_FIN;
                            end
                        end
                        OP_REMOVE: begin
                            if (raddr_q_reg == pos_reg) begin
                                data_next = mem_rdata;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = raddr_q_reg - 1'b1;
                                mem_wdata = mem_rdata;
                            end
                            if (rlast_reg) begin
                                state_next = ST_DONE;
                            end
                        end
                        OP_GET: begin
                            data_next  = mem_rdata;
                            state_next = ST_DONE;
                        end
                        OP_SET: begin
                            data_next  = mem_rdata;
                            mem_we     = 1'b1;
                            state_next = ST_DONE;
                        end
                        OP_INDEX: begin
                            if (mem_rdata == val_reg) begin
                                status_next  = STAT_OK;
                                found_next   = raddr_q_reg;
                                issuing_next = 1'b0;
                                state_next   = ST_DONE;
                            end else if (rlast_reg) begin
                                state_next = ST_DONE;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_FIN: begin
                // Place the new value once the entries above it have moved.
                mem_we     = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({COUNT_W'(count_reg),
                                                FOUND_W'(found_reg),
                                                DATA_W'(data_reg),
                                                status_reg});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            issuing_reg  <= 1'b0;
            rvalid_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            issuing_reg  <= issuing_next;
            rvalid_reg   <= rd_en;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload and walk registers.
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        status_reg  <= status_next;
        data_reg    <= data_next;
        found_reg   <= found_next;
        down_reg    <= down_next;
        rd_addr_reg <= rd_addr_next;
        rd_end_reg  <= rd_end_next;
        rlast_reg   <= (rd_addr_reg == rd_end_reg);
        raddr_q_reg <= rd_addr_reg;
        m_tdata_reg <= m_tdata_next;
    end

endmodule
